FILE: rtl/tcsq_pkg.sv
package tcsq_pkg;

  localparam int TAG_W = 8;
  localparam int CLS_W = 2;
  localparam int ARR_W = 16;
  localparam int SVC_W = 5;
  localparam int PRI_W = 4;
  localparam int ST_W  = 3;
  localparam int OUT_T_W = 16;

  localparam logic [CLS_W-1:0] CLS_HIGH = 2'd0;
  localparam logic [CLS_W-1:0] CLS_MID  = 2'd1;
  localparam logic [CLS_W-1:0] CLS_LOW  = 2'd2;

  localparam logic [ST_W-1:0] ST_IDLE     = 3'd0;
  localparam logic [ST_W-1:0] ST_RAN      = 3'd1;
  localparam logic [ST_W-1:0] ST_FINISHED = 3'd2;
  localparam logic [ST_W-1:0] ST_ENQUEUED = 3'd3;
  localparam logic [ST_W-1:0] ST_REJECTED = 3'd4;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_SLOT    = 1'b1;

  localparam logic [0:0] REG_SLOT_PERIOD = 1'b0;
  localparam logic [0:0] REG_HIGH_FIRST  = 1'b1;

  localparam logic [7:0] SLOT_PERIOD_RST = 8'd10;
  localparam logic [7:0] HIGH_FIRST_RST  = 8'd6;

  typedef struct packed {
    logic             operation;
    logic [TAG_W-1:0] job_tag;
    logic [CLS_W-1:0] job_class;
    logic [ARR_W-1:0] arrival_slot;
    logic [SVC_W-1:0] work_slots;
    logic [PRI_W-1:0] priority_req;
  } in_word_t;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [TAG_W-1:0]   job_tag_res;
    logic [CLS_W-1:0]   job_class_res;
    logic [OUT_T_W-1:0] slot_time;
    logic [OUT_T_W-1:0] turnaround_time;
    logic [OUT_T_W-1:0] queue_delay;
  } out_word_t;

  // one queue entry
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [ARR_W-1:0] arrive;
    logic [SVC_W-1:0] service;
    logic [PRI_W-1:0] prio;
    logic [SVC_W-1:0] remain;
  } job_t;

  // command from the controller to every cell of one queue
  typedef struct packed {
    logic       push;
    logic       pop;
    logic       dec;
    logic [ARR_W-1:0] key;
    job_t       job;
  } cell_cmd_t;

  function automatic logic [ARR_W-1:0] key_of(logic [CLS_W-1:0] cls, job_t j);
    logic [ARR_W-1:0] k;
    case (cls)
      CLS_HIGH: k = ARR_W'(j.prio);
      CLS_MID:  k = ARR_W'(j.service);
      default:  k = j.arrive;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/tcsq_cell.sv
module tcsq_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic [tcsq_pkg::CLS_W-1:0] cls,
  input  tcsq_pkg::cell_cmd_t cmd,
  input  logic                is_head,
  input  logic                left_valid,
  input  logic                left_ins,
  input  tcsq_pkg::job_t      left_job,
  input  logic                right_valid,
  input  tcsq_pkg::job_t      right_job,
  output logic                valid,
  output logic                ins,
  output tcsq_pkg::job_t      job
);
  import tcsq_pkg::*;

  logic valid_next;
  logic gt;

  // new key goes in front of this entry when this entry is strictly larger
  assign gt  = valid && (key_of(cls, job) > cmd.key);
  assign ins = gt;

  // keep occupancy as a thermometer code
  always_comb begin
    valid_next = valid;
    if (cmd.push)     valid_next = valid || left_valid;
    else if (cmd.pop) valid_next = right_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else     valid <= valid_next;
  end

  // shift right on insert, shift left on removal, count down the head
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      if (gt) begin
        job <= left_ins ? left_job : cmd.job;
      end else if (!valid && left_valid) begin
        job <= left_ins ? left_job : cmd.job;
      end
    end else if (cmd.pop) begin
      job <= right_job;
    end else if (cmd.dec && is_head) begin
      job.remain <= job.remain - SVC_W'(1);
    end
  end
endmodule

FILE: rtl/tcsq_chain.sv
module tcsq_chain #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [tcsq_pkg::CLS_W-1:0] cls,
  input  tcsq_pkg::cell_cmd_t cmd,
  output logic                empty,
  output logic                full,
  output tcsq_pkg::job_t      head
);
  import tcsq_pkg::*;

  logic [QUEUE_DEPTH:0] v;
  logic [QUEUE_DEPTH:0] ins;
  job_t                 jobs [QUEUE_DEPTH+1];

  // virtual cell before the head: always valid, marks the insert point
  assign v[0]    = 1'b1;
  assign ins[0]  = 1'b0;
  assign jobs[0] = cmd.job;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   rv;
    job_t   rj;
    if (i == QUEUE_DEPTH - 1) begin : g_end
      assign rv = 1'b0;
      assign rj = jobs[i+1];
    end else begin : g_mid
      assign rv = v[i+2];
      assign rj = jobs[i+2];
    end
    tcsq_cell u_cell (
      .clk(clk), .rst(rst), .cls(cls), .cmd(cmd), .is_head(i == 0),
      .left_valid(v[i]), .left_ins(ins[i]), .left_job(jobs[i]),
      .right_valid(rv), .right_job(rj),
      .valid(v[i+1]), .ins(ins[i+1]), .job(jobs[i+1])
    );
  end

  assign empty = !v[1];
  assign full  = v[QUEUE_DEPTH];
  assign head  = jobs[1];

  a_thermo: assert property (@(posedge clk) disable iff (rst)
    !v[QUEUE_DEPTH] || v[1]) else $error("occupancy not contiguous");
  a_push_fill: assert property (@(posedge clk) disable iff (rst)
    cmd.push && !full |=> !empty) else $error("push left queue empty");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && cmd.pop)) else $error("push and pop together");
endmodule

FILE: rtl/three_class_sorted_queue_scheduler_unit.sv
// Three-class sorted queue scheduler.
// Command channel: a word (in) is taken at a clock edge with start high and
// busy low. busy is always low, so a new word may be issued in every cycle.
// Each word produces exactly one result word on out, marked by done for one
// cycle, the cycle after the command was taken.
// The receiver cannot stall; out holds each result until the next word is taken.
// Enqueue places a job into its class queue, a chain of QUEUE_DEPTH cells
// that compare against the broadcast key and shift right in the same cycle.
// A slot word picks a head by the period order, decrements its remaining
// work, or removes it with a left shift through the chain.
// APB port: slot_period at 0x0, high_first_slots at 0x4, pready always high.
// Synchronous reset empties all queues, zeroes slot and phase counters and
// loads slot_period 10, high_first_slots 6. No clearing pass is needed.
module three_class_sorted_queue_scheduler_unit #(
  parameter int QUEUE_DEPTH = 32,
  parameter int TIME_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  tcsq_pkg::in_word_t   in,
  output logic                 done,
  output tcsq_pkg::out_word_t  out,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import tcsq_pkg::*;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  logic [7:0] slot_period, high_first_slots, period_phase;
  logic [TIME_BITS-1:0] current_slot;
  logic take, slot_op;
  cell_cmd_t cmd [3];
  logic [2:0] empty, full;
  job_t head [3];
  logic [CLS_W-1:0] sel;
  logic any;
  job_t hj;
  out_word_t res;
  logic [TIME_BITS:0] fin;
  logic [TIME_BITS:0] ta_w;
  logic [OUT_T_W-1:0] ta, wt;
  logic [7:0] phase_inc;
  logic wr;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign take   = start && !busy;
  assign slot_op = in.operation == OP_SLOT;

  // configuration registers
  assign wr = psel && penable && pwrite && pready;
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_period      <= SLOT_PERIOD_RST;
      high_first_slots <= HIGH_FIRST_RST;
    end else if (wr && paddr[1:0] == 2'b00 && paddr[2] == REG_SLOT_PERIOD) begin
      slot_period <= pwdata[7:0];
    end else if (wr && paddr[1:0] == 2'b00 && paddr[2] == REG_HIGH_FIRST) begin
      high_first_slots <= pwdata[7:0];
    end
  end
  assign prdata = paddr[2] == REG_HIGH_FIRST ? {24'd0, high_first_slots}
                                             : {24'd0, slot_period};

  // pick the queue to serve this slot
  always_comb begin
    any = 1'b1;
    if (period_phase < high_first_slots) begin
      if (!empty[0])      sel = CLS_HIGH;
      else if (!empty[1]) sel = CLS_MID;
      else                sel = CLS_LOW;
    end else begin
      if (!empty[1])      sel = CLS_MID;
      else if (!empty[0]) sel = CLS_HIGH;
      else                sel = CLS_LOW;
    end
    if (&empty) any = 1'b0;
    hj = head[sel];
  end

  // finish statistics
  assign fin  = {1'b0, current_slot} + (TIME_BITS+1)'(1);
  assign ta_w = fin > (TIME_BITS+1)'(hj.arrive) ? fin - (TIME_BITS+1)'(hj.arrive) : '0;
  assign ta   = ta_w > (TIME_BITS+1)'(16'hFFFF) ? 16'hFFFF : OUT_T_W'(ta_w);
  assign wt   = ta > OUT_T_W'(hj.service) ? ta - OUT_T_W'(hj.service) : '0;

  // broadcast commands to the chains
  for (genvar q = 0; q < 3; q++) begin : g_q
    job_t nj;
    always_comb begin
      nj.tag = in.job_tag;
      nj.arrive = in.arrival_slot;
      nj.service = in.work_slots;
      nj.prio = in.priority_req;
      nj.remain = in.work_slots;
      cmd[q].job  = nj;
      cmd[q].key  = key_of(CLS_W'(q), nj);
      cmd[q].push = take && !slot_op && in.job_class == CLS_W'(q) && !full[q];
      cmd[q].pop  = take && slot_op && any && sel == CLS_W'(q) && hj.remain <= SVC_W'(1);
      cmd[q].dec  = take && slot_op && any && sel == CLS_W'(q) && hj.remain > SVC_W'(1);
    end
    tcsq_chain #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_chain (
      .clk(clk), .rst(rst), .cls(CLS_W'(q)), .cmd(cmd[q]),
      .empty(empty[q]), .full(full[q]), .head(head[q])
    );
  end

  // build the result word
  always_comb begin
    res = '0;
    res.slot_time = OUT_T_W'(current_slot);
    if (!slot_op) begin
      res.job_tag_res   = in.job_tag;
      res.job_class_res = in.job_class;
      if (in.job_class == 2'd3 || full[in.job_class[1] ? 2 : in.job_class[0]])
        res.status = ST_REJECTED;
      else
        res.status = ST_ENQUEUED;
    end else if (any) begin
      res.job_tag_res   = hj.tag;
      res.job_class_res = sel;
      if (hj.remain > SVC_W'(1)) res.status = ST_RAN;
      else begin
        res.status = ST_FINISHED;
        res.turnaround_time = ta;
        res.queue_delay = wt;
      end
    end else begin
      res.status = ST_IDLE;
    end
  end

  // advance time and phase
  assign phase_inc = period_phase + 8'd1;
  always_ff @(posedge clk) begin
    if (rst) begin
      current_slot <= '0;
      period_phase <= '0;
      done         <= 1'b0;
    end else begin
      done <= take;
      if (take && slot_op) begin
        if (current_slot < TIME_MAX) current_slot <= current_slot + TIME_BITS'(1);
        period_phase <= ({1'b0, period_phase} + 9'd1 >= {1'b0, slot_period}) ? 8'd0
                                                                        : phase_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) out <= res;
  end

  a_done: assert property (@(posedge clk) disable iff (rst)
    start |=> done) else $error("missing result");
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd[0].push, cmd[1].push, cmd[2].push, cmd[0].pop, cmd[1].pop,
              cmd[2].pop, cmd[0].dec, cmd[1].dec, cmd[2].dec}))
    else $error("more than one queue touched");
  a_slot: assert property (@(posedge clk) disable iff (rst)
    !(start && slot_op) |=> $stable(current_slot)) else $error("slot moved");
endmodule

FILE: tb/testbench.sv
module testbench;
  import tcsq_pkg::*;

  localparam int IN_W = $bits(in_word_t);

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  in_word_t    in;
  logic        done;
  out_word_t   out;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  three_class_sorted_queue_scheduler_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in(in),
    .done(done), .out(out), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // scheduler mirror: sorted class queues, counters, registers
  job_t        class_jobs[3][$];
  logic [15:0] sched_slot;
  logic [7:0]  sched_phase;
  logic [7:0]  sched_period;
  logic [7:0]  sched_high_first;
  out_word_t   pending_words[$];
  int          idle_pct;
  int          errors;
  int          words_sent;
  int          words_checked;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(12 * 2000000);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [15:0] order_key(int cls, job_t j);
    if (cls == 0) return 16'(j.prio);
    if (cls == 1) return 16'(j.service);
    return j.arrive;
  endfunction

  function automatic int jobs_queued();
    return class_jobs[0].size() + class_jobs[1].size() + class_jobs[2].size();
  endfunction

  // compute the result word of one command and advance the mirror
  task automatic schedule_word(input in_word_t w, output out_word_t r);
    job_t        j;
    int          cls;
    int          pos;
    int          pick;
    logic [16:0] fin;
    logic [16:0] ta;
    logic [16:0] wt;
    logic [8:0]  nxt;
    r = '0;
    r.slot_time = sched_slot;
    if (w.operation == OP_ENQUEUE) begin
      cls = int'(w.job_class);
      r.job_tag_res = w.job_tag;
      r.job_class_res = w.job_class;
      if (cls > 2 || class_jobs[cls].size() >= 32) begin
        r.status = ST_REJECTED;
      end else begin
        j.tag = w.job_tag;
        j.arrive = w.arrival_slot;
        j.service = w.work_slots;
        j.prio = w.priority_req;
        j.remain = w.work_slots;
        pos = 0;
        while (pos < class_jobs[cls].size() &&
               order_key(cls, class_jobs[cls][pos]) <= order_key(cls, j)) pos++;
        class_jobs[cls].insert(pos, j);
        r.status = ST_ENQUEUED;
      end
    end else begin
      // search order depends on where we are in the share period
      pick = -1;
      if (sched_phase < sched_high_first) begin
        if (class_jobs[0].size() > 0) pick = 0;
        else if (class_jobs[1].size() > 0) pick = 1;
      end else begin
        if (class_jobs[1].size() > 0) pick = 1;
        else if (class_jobs[0].size() > 0) pick = 0;
      end
      if (pick < 0 && class_jobs[2].size() > 0) pick = 2;
      if (pick < 0) begin
        r.status = ST_IDLE;
      end else begin
        j = class_jobs[pick][0];
        r.job_tag_res = j.tag;
        r.job_class_res = 2'(pick);
        if (j.remain > 1) begin
          class_jobs[pick][0].remain = j.remain - 1'b1;
          r.status = ST_RAN;
        end else begin
          fin = {1'b0, sched_slot} + 17'd1;
          ta = (fin > 17'(j.arrive)) ? fin - 17'(j.arrive) : 17'd0;
          if (ta > 17'hFFFF) ta = 17'hFFFF;
          wt = (ta > 17'(j.service)) ? ta - 17'(j.service) : 17'd0;
          r.status = ST_FINISHED;
          r.turnaround_time = ta[15:0];
          r.queue_delay = wt[15:0];
          void'(class_jobs[pick].pop_front());
        end
      end
      if (sched_slot != 16'hFFFF) sched_slot = sched_slot + 1'b1;
      nxt = {1'b0, sched_phase} + 9'd1;
      sched_phase = (nxt >= {1'b0, sched_period}) ? 8'd0 : nxt[7:0];
    end
  endtask

  // check each result word, then predict the command taken at this edge
  always @(posedge clk) begin
    out_word_t want;
    if (!rst) begin
      if (done) begin
        if (pending_words.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %h", out);
        end else begin
          want = pending_words.pop_front();
          words_checked++;
          if (out.status !== want.status || out.job_tag_res !== want.job_tag_res ||
              out.job_class_res !== want.job_class_res ||
              out.slot_time !== want.slot_time ||
              out.turnaround_time !== want.turnaround_time ||
              out.queue_delay !== want.queue_delay) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected st=%0d tag=%0d cls=%0d slot=%0d ta=%0d wt=%0d",
                       want.status, want.job_tag_res, want.job_class_res, want.slot_time,
                       want.turnaround_time, want.queue_delay);
              $display("          got      st=%0d tag=%0d cls=%0d slot=%0d ta=%0d wt=%0d",
                       out.status, out.job_tag_res, out.job_class_res, out.slot_time,
                       out.turnaround_time, out.queue_delay);
            end
          end
        end
      end
      if (start && !busy) begin
        schedule_word(in, want);
        pending_words.push_back(want);
        words_sent++;
      end
    end
  end

  // send one command word, idling at random first
  task automatic send_word(input in_word_t w);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_job(input logic [7:0] tag, input logic [1:0] cls,
                          input logic [15:0] arr, input logic [4:0] svc,
                          input logic [3:0] pri);
    in_word_t w;
    w.operation = OP_ENQUEUE;
    w.job_tag = tag;
    w.job_class = cls;
    w.arrival_slot = arr;
    w.work_slots = svc;
    w.priority_req = pri;
    send_word(w);
  endtask

  task automatic send_slot();
    in_word_t w;
    w = in_word_t'(IN_W'({$urandom(), $urandom()}));
    w.operation = OP_SLOT;
    send_word(w);
  endtask

  // drop start and hold until every result word has arrived
  task automatic drain_words();
    @(negedge clk);
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // register write followed by a readback
  task automatic write_reg(input int idx, input logic [7:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 3'(4 * idx); pwdata <= {8'($urandom_range(255)), 16'h0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == int'(REG_SLOT_PERIOD)) sched_period = val;
    else sched_high_first = val;
    @(negedge clk);
    pwrite <= 1'b0; penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[7:0] !== val) begin
      errors++;
      if (errors <= 10)
        $display("readback reg %0d: expected %0d, got %0d", idx, val, prdata[7:0]);
    end
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  task automatic run_out_jobs();
    while (jobs_queued() > 0) send_slot();
    drain_words();
  endtask

  // extremes of the fields, every status, zero service, late arrival, bad class
  task automatic test_directed();
    send_slot();
    send_job(8'hFF, CLS_HIGH, 16'h0000, 5'd2, 4'd15);
    send_job(8'h00, CLS_HIGH, 16'hFFFF, 5'd1, 4'd0);
    send_job(8'h11, CLS_HIGH, 16'h0010, 5'd1, 4'd15);
    send_job(8'h22, CLS_MID, 16'h0000, 5'd31, 4'd3);
    send_job(8'h33, CLS_MID, 16'h0001, 5'd0, 4'd3);
    send_job(8'h44, CLS_MID, 16'h0002, 5'd0, 4'd3);
    send_job(8'h55, CLS_LOW, 16'hFFFF, 5'd1, 4'd1);
    send_job(8'h66, CLS_LOW, 16'h0000, 5'd3, 4'd1);
    send_job(8'hA5, 2'd3, 16'h5A5A, 5'd21, 4'd10);
    repeat (12) send_slot();
    send_job(8'h5A, CLS_LOW, 16'hFFFF, 5'd1, 4'd0);
    run_out_jobs();
  endtask

  // fill one queue past its depth, then empty it
  task automatic test_full_queue();
    for (int k = 0; k < 35; k++)
      send_job(8'($urandom()), CLS_MID, 16'($urandom()), 5'($urandom_range(2)), 4'($urandom()));
    send_job(8'h77, CLS_HIGH, 16'h0, 5'd1, 4'd7);
    run_out_jobs();
  endtask

  // mostly well-formed traffic with random content, a little noise
  task automatic test_random(input int count);
    in_word_t w;
    for (int k = 0; k < count; k++) begin
      if (k == count / 2) drain_words();
      w = in_word_t'(IN_W'({$urandom(), $urandom()}));
      if ($urandom_range(99) < 45) begin
        w.operation = OP_ENQUEUE;
        w.job_class = ($urandom_range(99) < 4) ? 2'd3 : 2'($urandom_range(2));
        if ($urandom_range(3) != 0) w.work_slots = 5'($urandom_range(4));
        if ($urandom_range(1) != 0) w.arrival_slot = sched_slot - 16'($urandom_range(40));
      end else begin
        w.operation = OP_SLOT;
      end
      send_word(w);
    end
    drain_words();
  endtask

  // a one-slot period with the high queue always searched first
  task automatic test_short_period();
    send_job(8'hC3, CLS_LOW, 16'h0000, 5'd1, 4'd2);
    send_job(8'h3C, CLS_HIGH, 16'h0000, 5'd2, 4'd9);
    run_out_jobs();
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    in = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    errors = 0; words_sent = 0; words_checked = 0;
    sched_slot = '0; sched_phase = '0;
    sched_period = SLOT_PERIOD_RST;
    sched_high_first = HIGH_FIRST_RST;
    idle_pct = 29;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_queue();
    test_random(230);

    idle_pct = 54;
    write_reg(int'(REG_SLOT_PERIOD), 8'd255);
    write_reg(int'(REG_HIGH_FIRST), 8'd255);
    test_random(110);
    write_reg(int'(REG_SLOT_PERIOD), 8'd0);
    write_reg(int'(REG_HIGH_FIRST), 8'd0);
    test_random(110);

    idle_pct = 0;
    write_reg(int'(REG_SLOT_PERIOD), 8'd4);
    write_reg(int'(REG_HIGH_FIRST), 8'd2);
    test_random(230);
    write_reg(int'(REG_SLOT_PERIOD), 8'd1);
    write_reg(int'(REG_HIGH_FIRST), 8'd1);
    test_short_period();

    drain_words();
    repeat (5) @(posedge clk);
    $display("covered %0d command words, %0d result words checked", words_sent, words_checked);
    $display("queue fill and reject, five register settings, idle and back-to-back traffic");
    if (errors == 0 && pending_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: three_class_sorted_queue_scheduler_unit.f
rtl/tcsq_pkg.sv
rtl/tcsq_cell.sv
rtl/tcsq_chain.sv
rtl/three_class_sorted_queue_scheduler_unit.sv
tb/testbench.sv
